>>> design/axcbc_pkg.sv
package axcbc_pkg;

  localparam int TAG_BYTES = 12;
  localparam int BLK_BYTES = 16;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [0:0] CFG_KEY_HI = 1'b0;
  localparam logic [0:0] CFG_KEY_LO = 1'b1;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic busy;
  } kstat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // next round key; byte 0 is the MSB
  function automatic blk_t key_step(input blk_t k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

  function automatic blk_t enc_round(input blk_t s, input blk_t rk, input logic final_rnd);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    blk_t o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i+4*c] = SBOX[b[i+4*((c+i)&3)]];
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    enc_round = o ^ rk;
  endfunction

endpackage

>>> design/axcbc_aes.sv
// Full AES-128 encrypt, all ten rounds with on-the-fly key expansion.
module axcbc_aes (
  input  axcbc_pkg::blk_t key,
  input  axcbc_pkg::blk_t din,
  output axcbc_pkg::blk_t dout
);
  import axcbc_pkg::*;

  blk_t rk [11];
  blk_t st [11];

  assign rk[0] = key;
  assign st[0] = din ^ key;

  for (genvar r = 1; r <= 10; r++) begin : g_rnd
    assign rk[r] = key_step(rk[r-1], RCON[r-1]);
    assign st[r] = enc_round(st[r-1], rk[r], r == 10);
  end

  assign dout = st[10];
endmodule

>>> design/axcbc_keygen.sv
// Derives K1..K3 one per cycle after reset or a key write.
module axcbc_keygen (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            key_wr,
  input  axcbc_pkg::blk_t key,
  output axcbc_pkg::blk_t k1,
  output axcbc_pkg::blk_t k2,
  output axcbc_pkg::blk_t k3,
  output axcbc_pkg::kstat_t stat
);
  import axcbc_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  blk_t       k1_r, k2_r, k3_r, enc;

  axcbc_aes u_aes (.key(key), .din({16{6'd0, idx_r}}), .dout(enc));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (key_wr) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd1;
    end else if (busy_r) begin
      if (idx_r == 2'd3) busy_nxt = 1'b0;
      else idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd1;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    if (busy_r && !key_wr) begin
      case (idx_r)
        2'd1:    k1_r <= enc;
        2'd2:    k2_r <= enc;
        2'd3:    k3_r <= enc;
        default: ;
      endcase
    end
  end

  assign k1 = k1_r;
  assign k2 = k2_r;
  assign k3 = k3_r;
  assign stat.busy = busy_r;
endmodule

>>> design/aes_xcbc_mac_96.sv
// AES-XCBC-MAC-96 (RFC 3566) tag engine. One 128-bit message block per cycle:
// an accepted block is XORed into the chain (with K2, or padding and K3, when
// it is the last one) and run through a fully unrolled ten-round AES under K1
// in the same cycle, so the chain is ready for the next block in the following cycle.
// A last block produces one item carrying the upper 96 bits of the result in
// an output register; the chain then clears. While a tag waits on out_ready,
// no further block is accepted; input resumes in the cycle the tag is taken.
// After reset and after each key register write the block derives K1..K3 with a
// second AES core and accepts no item meanwhile; config writes go in when idle,
// which the user must ensure: the block itself does not enforce it.
module aes_xcbc_mac_96 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  input  logic [4:0]  in_byte_count,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_tag_hi,
  output logic [31:0] out_tag_lo
);
  import axcbc_pkg::*;

  logic [63:0] key_hi_r, key_lo_r;
  blk_t        chain_r, chain_nxt, k1, k2, k3, msg, aes_in, aes_out;
  kstat_t      kst;
  logic        out_valid_r, acc, cfg_wr;
  logic [95:0] tag_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_KEY_HI: key_hi_r <= cfg_data;
        CFG_KEY_LO: key_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  axcbc_keygen u_keygen (
    .clk, .rst_n, .key_wr(cfg_wr), .key({key_hi_r, key_lo_r}),
    .k1, .k2, .k3, .stat(kst)
  );

  // Ready when keys are settled and the tag slot is free or draining.
  assign in_ready = !kst.busy && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;

  // Last-block formatting: full block with K2, else pad 0x80 + zeros with K3.
  always_comb begin
    msg = {in_block_hi, in_block_lo};
    if (in_last_block) begin
      if (in_byte_count >= 5'(BLK_BYTES)) begin
        msg = msg ^ k2;
      end else begin
        for (int i = 0; i < BLK_BYTES; i++) begin
          if (i > int'(in_byte_count)) msg[127-8*i -: 8] = 8'h00;
          else if (i == int'(in_byte_count)) msg[127-8*i -: 8] = PAD_BYTE;
        end
        msg = msg ^ k3;
      end
    end
  end

  assign aes_in = chain_r ^ msg;
  axcbc_aes u_aes (.key(k1), .din(aes_in), .dout(aes_out));

  always_comb begin
    chain_nxt = chain_r;
    if (acc) chain_nxt = in_last_block ? '0 : aes_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chain_r <= chain_nxt;
      if (acc && in_last_block) out_valid_r <= 1'b1;
      else if (out_ready)       out_valid_r <= 1'b0;
    end
    if (acc && in_last_block) begin
      for (int i = 0; i < 12; i++)
        tag_r[95-8*i -: 8] <= (i < TAG_BYTES) ? aes_out[127-8*i -: 8] : 8'h00;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_tag_hi = tag_r[95:32];
  assign out_tag_lo = tag_r[31:0];

endmodule

>>> design/axcbc_checker.sv
module axcbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_block,
  input logic        cfg_valid,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_tag_hi,
  input logic [31:0] out_tag_lo
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tag_hi) && $stable(out_tag_lo))
    else $error("tag changed while stalled");

  a_tag_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_block |=> out_valid)
    else $error("no tag after last block");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready && in_last_block) |=> !out_valid)
    else $error("tag without last block");

  a_key_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> !in_ready)
    else $error("input taken during key derivation");

endmodule

bind aes_xcbc_mac_96 axcbc_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .in_last_block, .cfg_valid,
  .out_valid, .out_ready, .out_tag_hi, .out_tag_lo
);

>>> tb/sv/tb_top.sv
module tb_top;
  import axcbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog: idle cycles with no item accepted on any channel.
  // Covers the longest sender gap, the longest receiver stall and
  // the subkey derivation after every key write, with a wide margin.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [63:0] tag_hi;
    logic [31:0] tag_lo;
  } tag_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_KEY_HI;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_block_hi = '0;
  logic [63:0] in_block_lo = '0;
  logic [4:0]  in_byte_count = '0;
  logic        in_last_block = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_tag_hi;
  logic [31:0] out_tag_lo;

  always #5 clk = ~clk;

  aes_xcbc_mac_96 u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_block_hi(in_block_hi), .in_block_lo(in_block_lo),
    .in_byte_count(in_byte_count), .in_last_block(in_last_block),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tag_hi(out_tag_hi), .out_tag_lo(out_tag_lo)
  );

  // ---------------- tag predictor ----------------
  logic [63:0] mdl_key_hi, mdl_key_lo;
  blk_t        mdl_chain;
  blk_t        mdl_k1, mdl_k2, mdl_k3;
  tag_t        tags_pending[$];

  int errors = 0;
  int blocks_sent = 0;
  int tags_seen = 0;
  int key_writes = 0;
  int short_tails = 0;
  int idle_cycles = 0;

  // Plain AES-128, written byte-wise; byte 0 is the MSB of the vector.
  function automatic logic [7:0] gmul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t aes_encrypt(blk_t pt, blk_t key);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] t [16];
    logic [7:0] w0, w1, w2, w3, tmp, a0, a1, a2, a3, al;
    blk_t res;
    for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
      if ((i % 16) == 0) begin
        tmp = w0;
        w0 = SBOX[w1] ^ RCON[i/16 - 1];
        w1 = SBOX[w2];
        w2 = SBOX[w3];
        w3 = SBOX[tmp];
      end
      rk[i] = rk[i-16] ^ w0;
      rk[i+1] = rk[i-15] ^ w1;
      rk[i+2] = rk[i-14] ^ w2;
      rk[i+3] = rk[i-13] ^ w3;
    end
    for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = SBOX[st[i+4*((c+i)%4)]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  function automatic void derive_subkeys();
    blk_t k;
    k = {mdl_key_hi, mdl_key_lo};
    mdl_k1 = aes_encrypt({16{8'h01}}, k);
    mdl_k2 = aes_encrypt({16{8'h02}}, k);
    mdl_k3 = aes_encrypt({16{8'h03}}, k);
  endfunction

  // Fold one accepted block into the chain; a last block yields a tag.
  function automatic void predict_block(logic [63:0] bhi, logic [63:0] blo,
                                        logic [4:0] cnt, logic last);
    blk_t msg, padded;
    tag_t tg;
    msg = {bhi, blo};
    if (!last) begin
      mdl_chain = aes_encrypt(mdl_chain ^ msg, mdl_k1);
      return;
    end
    if (cnt >= 5'd16) begin
      mdl_chain = aes_encrypt(mdl_chain ^ msg ^ mdl_k2, mdl_k1);
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (i < cnt) padded[127-8*i -: 8] = msg[127-8*i -: 8];
        else if (i == cnt) padded[127-8*i -: 8] = PAD_BYTE;
        else padded[127-8*i -: 8] = 8'h00;
      end
      mdl_chain = aes_encrypt(mdl_chain ^ padded ^ mdl_k3, mdl_k1);
    end
    for (int i = 0; i < 12; i++) begin
      if (i >= TAG_BYTES) mdl_chain[127-8*i -: 8] = 8'h00;
    end
    tg.tag_hi = mdl_chain[127:64];
    tg.tag_lo = mdl_chain[63:32];
    tags_pending.push_back(tg);
    mdl_chain = '0;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("ERROR @%0t: %s got %h want %h", $time, what, got, want);
  endtask

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tag_t want;
      if (tags_pending.size() == 0) begin
        report_mismatch("unexpected tag item", out_tag_hi, '0);
      end else begin
        want = tags_pending.pop_front();
        tags_seen++;
        if (out_tag_hi !== want.tag_hi) report_mismatch("tag_hi", out_tag_hi, want.tag_hi);
        if (out_tag_lo !== want.tag_lo)
          report_mismatch("tag_lo", {32'h0, out_tag_lo}, {32'h0, want.tag_lo});
      end
    end
  end

  // Receiver stalls: mostly short, sometimes long, sometimes none.
  bit stall_enable = 1'b1;
  int stall_left = 0;
  always @(posedge clk) begin
    if (!stall_enable) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d tags still pending", tags_pending.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- drivers ----------------
  bit gaps_enable = 1'b1;

  // Valid drops here only when a gap is taken, so back-to-back items keep it high.
  task automatic sender_gap();
    int n;
    if (!gaps_enable) return;
    if ($urandom_range(0, 2) != 0) return;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send one block item; the predictor sees it at acceptance.
  task automatic send_block(logic [63:0] bhi, logic [63:0] blo, logic [4:0] cnt, logic last);
    sender_gap();
    in_valid <= 1'b1;
    in_block_hi <= bhi;
    in_block_lo <= blo;
    in_byte_count <= cnt;
    in_last_block <= last;
    do @(posedge clk); while (!in_ready);
    predict_block(bhi, blo, cnt, last);
    blocks_sent++;
    if (last && cnt < 5'd16) short_tails++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tags_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Key write; only done with the engine idle.
  task automatic write_key(logic [0:0] idx, logic [63:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_KEY_HI) mdl_key_hi = val;
    else mdl_key_lo = val;
    derive_subkeys();
    key_writes++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [4:0] rand_tail_count();
    case ($urandom_range(0, 5))
      0: return 5'd16;
      1: return 5'd0;
      2: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 15));
    endcase
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    // Empty message: single empty last block
    send_block('0, '0, 5'd0, 1'b1);
    // Single full last block, all ones and all zeros
    send_block('1, '1, 5'd16, 1'b1);
    send_block('0, '0, 5'd16, 1'b1);
    // Every short count; bytes past the count are noise and must be dropped
    for (int n = 1; n < 16; n++) send_block(rand64(), rand64(), 5'(n), 1'b1);
    // Count above sixteen treated as full
    send_block(rand64(), rand64(), 5'd17, 1'b1);
    send_block(rand64(), rand64(), 5'd31, 1'b1);
    // Non-last block ignores its count (IV-style leading block)
    send_block('1, '0, 5'd0, 1'b0);
    send_block('0, '1, 5'd3, 1'b0);
    send_block(rand64(), rand64(), 5'd31, 1'b1);
    wait_drained();
  endtask

  task automatic test_key_extremes();
    write_key(CFG_KEY_HI, '1);
    write_key(CFG_KEY_LO, '1);
    send_block(rand64(), rand64(), 5'd16, 1'b1);
    send_block(rand64(), rand64(), 5'd5, 1'b1);
    write_key(CFG_KEY_HI, '0);
    send_block('0, '0, 5'd0, 1'b1);
    write_key(CFG_KEY_LO, '0);
    send_block('1, '1, 5'd16, 1'b1);
    wait_drained();
  endtask

  task automatic test_key_mid_message();
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    // no tag pending, so the engine is idle once the block has gone in
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    write_key(CFG_KEY_LO, rand64());
    send_block(rand64(), rand64(), 5'd16, 1'b0);
    send_block(rand64(), rand64(), rand_tail_count(), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_messages(int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 40) == 0) write_key(1'($urandom_range(0, 1)), rand64());
      // Pressure: sometimes hold off until every tag is back
      if ($urandom_range(0, 20) == 0) wait_drained();
      // Occasional stretch with no idling on either side
      gaps_enable = ($urandom_range(0, 5) != 0);
      stall_enable = gaps_enable;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      for (int i = 0; i < len - 1; i++) begin
        send_block(rand64(), rand64(), 5'($urandom()), 1'b0);
        sent++;
      end
      send_block(rand64(), rand64(), rand_tail_count(), 1'b1);
      sent++;
    end
    gaps_enable = 1'b1;
    stall_enable = 1'b1;
    wait_drained();
  endtask

  initial begin
    mdl_key_hi = '0;
    mdl_key_lo = '0;
    mdl_chain = '0;
    derive_subkeys();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_key_extremes();
    test_key_mid_message();
    test_random_messages(880);

    repeat (20) @(posedge clk);
    $display("covered %0d blocks, %0d tags (%0d short tails), %0d key writes",
             blocks_sent, tags_seen, short_tails, key_writes);
    if (errors == 0 && tags_pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d tags never arrived", errors, tags_pending.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
